// ----- rtl/jsu_pkg.sv -----
// Shared types and constants of the JSON string unescaper.
// Used by every file in rtl/; depends on nothing else.
package jsu_pkg;

  // Largest output buffer the block is built for; the effective capacity saturates here.
  localparam int MAX_CAPACITY = 4096;
  localparam int CAP_W        = 13;
  localparam int LEN_W        = 12;
  localparam logic [CAP_W-1:0] CAP_LIMIT =
    CAP_W'((MAX_CAPACITY < 4096) ? MAX_CAPACITY : 4096);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  // Request queue between the front end and the decode engine.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    PH_TEXT,
    PH_RAW,
    PH_ESC,
    PH_HEX,
    PH_WANT_BS,
    PH_WANT_U,
    PH_LOW_HEX
  } phase_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic             is_status;
    logic [7:0]       out_byte;
    logic [LEN_W-1:0] value_length;
    logic             truncated;
    logic             last;
  } out_item_t;

  // What one decode step hands to the output side: up to four bytes of one
  // unit, an optional status record, and whether the request is now finished.
  typedef struct packed {
    logic [2:0]       nb;
    logic [3:0][7:0]  ub;
    logic             has_status;
    logic [LEN_W-1:0] len;
    logic             trunc;
    logic             item_end;
  } step_t;

endpackage

// ----- rtl/jsu_front.sv -----
// Front end of the JSON string unescaper: accepts requests and queues them.
// Depends on jsu_pkg.
module jsu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  jsu_pkg::in_item_t  in_item,
  output logic               q_valid,
  output logic [7:0]         q_byte,
  input  logic               q_pop
);

  logic [jsu_pkg::QUEUE_DEPTH-1:0][7:0] mem_r;
  logic [jsu_pkg::QPTR_W-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic [jsu_pkg::QPTR_W-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [jsu_pkg::QCNT_W-1:0]           cnt_r, cnt_nxt;
  logic                                 push;
  logic [7:0]                           feed_byte;

  // The end marker behaves exactly like a zero data byte, so it is folded here.
  assign feed_byte = in_item.cmd ? 8'h00 : in_item.in_byte;

  assign in_ready = (cnt_r != jsu_pkg::QCNT_W'(jsu_pkg::QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_byte   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == jsu_pkg::QPTR_W'(jsu_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == jsu_pkg::QPTR_W'(jsu_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= feed_byte;
    end
  end

endmodule

// ----- rtl/jsu_engine.sv -----
// Decode engine of the JSON string unescaper: escape, surrogate and UTF-8
// handling, capacity accounting and byte replay. Depends on jsu_pkg.
module jsu_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [jsu_pkg::CAP_W-1:0] cap,
  input  logic                      q_valid,
  input  logic [7:0]                q_byte,
  output logic                      q_pop,
  output logic                      step_valid,
  output jsu_pkg::step_t            step,
  input  logic                      step_ready
);

  localparam int REPLAY_DEPTH = 6;
  localparam int RP_CW        = $clog2(REPLAY_DEPTH + 1);

  localparam logic [7:0]  CH_QUOTE  = 8'h22;
  localparam logic [7:0]  CH_BSLASH = 8'h5C;
  localparam logic [7:0]  CH_U      = 8'h75;
  localparam logic [15:0] HI_FIRST  = 16'hD800;
  localparam logic [15:0] HI_LAST   = 16'hDBFF;
  localparam logic [15:0] LO_FIRST  = 16'hDC00;
  localparam logic [15:0] LO_LAST   = 16'hDFFF;
  localparam logic [20:0] CP_REPL   = 21'h00FFFD;
  localparam logic [20:0] CP_PLANE1 = 21'h010000;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } unit_t;

  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] n;
    if (!b[7])                    n = 3'd1;
    else if (b[7:5] == 3'b110)    n = 3'd2;
    else if (b[7:4] == 4'b1110)   n = 3'd3;
    else if (b[7:3] == 5'b11110)  n = 3'd4;
    else                          n = 3'd1;
    return n;
  endfunction

  // Returns {valid, value} of one hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [7:0] d;
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = b - 8'h30;
      r = {1'b1, d[3:0]};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d = b - 8'h57;
      r = {1'b1, d[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d = b - 8'h37;
      r = {1'b1, d[3:0]};
    end
    return r;
  endfunction

  function automatic logic [7:0] esc_map(input logic [7:0] b);
    logic [7:0] r;
    unique case (b)
      8'h6E:   r = 8'h0A;
      8'h74:   r = 8'h09;
      8'h72:   r = 8'h0D;
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      default: r = b;
    endcase
    return r;
  endfunction

  function automatic unit_t encode_cp(input logic [20:0] cp);
    unit_t u;
    u = '0;
    if (cp < 21'h80) begin
      u.n    = 3'd1;
      u.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      u.n    = 3'd2;
      u.b[0] = {3'b110, cp[10:6]};
      u.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      u.n    = 3'd3;
      u.b[0] = {4'b1110, cp[15:12]};
      u.b[1] = {2'b10, cp[11:6]};
      u.b[2] = {2'b10, cp[5:0]};
    end else begin
      u.n    = 3'd4;
      u.b[0] = {5'b11110, cp[20:18]};
      u.b[1] = {2'b10, cp[17:12]};
      u.b[2] = {2'b10, cp[11:6]};
      u.b[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

  jsu_pkg::phase_t                   phase_r, phase_nxt;
  logic [15:0]                       hex_accum_r, hex_accum_nxt;
  logic [2:0]                        hex_count_r, hex_count_nxt;
  logic [15:0]                       high_half_r, high_half_nxt;
  logic [3:0][7:0]                   raw_hold_r, raw_hold_nxt;
  logic [2:0]                        raw_need_r, raw_need_nxt;
  logic [2:0]                        raw_have_r, raw_have_nxt;
  logic [jsu_pkg::LEN_W-1:0]         wc_r, wc_nxt;
  logic                              stopped_r, stopped_nxt;
  logic [REPLAY_DEPTH-1:0][7:0]      rp_buf_r;
  logic [RP_CW-1:0]                  rp_cnt_r;
  logic                              step_valid_r;
  jsu_pkg::step_t                    step_r, step_nxt;

  logic                              src_rp, src_valid, can_step, fire;
  logic [7:0]                        b;
  logic                              is_end;
  logic [4:0]                        hx;
  logic [15:0]                       accum_w;
  logic [2:0]                        cnt_inc, have_inc;
  logic [1:0]                        hn;
  logic                              cp_req;
  logic [20:0]                       cp_val;
  unit_t                             enc;
  logic                              emit_req;
  logic [2:0]                        unit_n;
  logic [3:0][7:0]                   unit_b;
  logic                              fin;
  logic [RP_CW-1:0]                  push_n;
  logic [REPLAY_DEPTH-1:0][7:0]      push_b;
  logic [jsu_pkg::CAP_W-1:0]         cap_eff;
  logic [jsu_pkg::CAP_W:0]           wsum;
  logic [2:0]                        out_nb;
  logic [jsu_pkg::LEN_W-1:0]         wc_emit;
  logic                              stopped_emit;

  // Replayed bytes take priority over new requests from the queue.
  assign src_rp     = (rp_cnt_r != '0);
  assign src_valid  = src_rp || q_valid;
  assign b          = src_rp ? rp_buf_r[0] : q_byte;
  assign can_step   = !step_valid_r || step_ready;
  assign fire       = can_step && src_valid;
  assign q_pop      = fire && !src_rp;
  assign step_valid = step_valid_r;
  assign step       = step_r;

  assign is_end  = (b == 8'h00) || (b == CH_QUOTE);
  assign hx      = hex_digit(b);
  assign accum_w = {hex_accum_r[11:0], hx[3:0]};
  assign cnt_inc = hex_count_r + 3'd1;
  assign have_inc = raw_have_r + 3'd1;
  assign hn      = hex_count_r[1:0];
  assign cap_eff = (cap > jsu_pkg::CAP_LIMIT) ? jsu_pkg::CAP_LIMIT : cap;

  always_comb begin
    phase_nxt     = phase_r;
    hex_accum_nxt = hex_accum_r;
    hex_count_nxt = hex_count_r;
    high_half_nxt = high_half_r;
    raw_hold_nxt  = raw_hold_r;
    raw_need_nxt  = raw_need_r;
    raw_have_nxt  = raw_have_r;
    wc_nxt        = wc_r;
    stopped_nxt   = stopped_r;
    cp_req        = 1'b0;
    cp_val        = '0;
    emit_req      = 1'b0;
    unit_n        = '0;
    unit_b        = '0;
    fin           = 1'b0;
    push_n        = '0;
    push_b        = '0;

    unique case (phase_r)
      jsu_pkg::PH_TEXT: begin
        if (is_end) begin
          fin = 1'b1;
        end else if (b == CH_BSLASH) begin
          phase_nxt = jsu_pkg::PH_ESC;
        end else if (seq_len(b) == 3'd1) begin
          emit_req  = 1'b1;
          unit_n    = 3'd1;
          unit_b[0] = b;
        end else begin
          raw_hold_nxt[0] = b;
          raw_need_nxt    = seq_len(b);
          raw_have_nxt    = 3'd1;
          phase_nxt       = jsu_pkg::PH_RAW;
        end
      end
      jsu_pkg::PH_RAW: begin
        if (is_end) begin
          // A sequence cut short still goes out as one unit.
          emit_req = 1'b1;
          unit_n   = raw_have_r;
          unit_b   = raw_hold_r;
          fin      = 1'b1;
        end else begin
          raw_hold_nxt[raw_have_r[1:0]] = b;
          if (have_inc >= raw_need_r) begin
            emit_req     = 1'b1;
            unit_n       = raw_need_r;
            unit_b       = raw_hold_nxt;
            phase_nxt    = jsu_pkg::PH_TEXT;
            raw_have_nxt = '0;
            raw_need_nxt = '0;
          end else begin
            raw_have_nxt = have_inc;
          end
        end
      end
      jsu_pkg::PH_ESC: begin
        phase_nxt = jsu_pkg::PH_TEXT;
        if (b == 8'h00) begin
          fin = 1'b1;
        end else if (b == CH_U) begin
          phase_nxt     = jsu_pkg::PH_HEX;
          hex_count_nxt = '0;
          hex_accum_nxt = '0;
        end else begin
          emit_req  = 1'b1;
          unit_n    = 3'd1;
          unit_b[0] = esc_map(b);
        end
      end
      jsu_pkg::PH_HEX, jsu_pkg::PH_LOW_HEX: begin
        if (hx[4]) begin
          raw_hold_nxt[hn] = b;
          hex_accum_nxt    = accum_w;
          if (cnt_inc < 3'd4) begin
            hex_count_nxt = cnt_inc;
          end else begin
            phase_nxt     = jsu_pkg::PH_TEXT;
            hex_count_nxt = '0;
            if (phase_r == jsu_pkg::PH_HEX) begin
              if (accum_w >= HI_FIRST && accum_w <= HI_LAST) begin
                high_half_nxt = accum_w;
                phase_nxt     = jsu_pkg::PH_WANT_BS;
              end else if (accum_w >= LO_FIRST && accum_w <= LO_LAST) begin
                cp_req = 1'b1;
                cp_val = CP_REPL;
              end else begin
                cp_req = 1'b1;
                cp_val = 21'(accum_w);
              end
            end else if (accum_w >= LO_FIRST && accum_w <= LO_LAST) begin
              cp_req = 1'b1;
              cp_val = CP_PLANE1 + 21'({high_half_r[9:0], accum_w[9:0]});
            end else begin
              // Second escape is no low half: replacement, then the whole
              // escape is read again as text.
              cp_req    = 1'b1;
              cp_val    = CP_REPL;
              push_b[0] = CH_BSLASH;
              push_b[1] = CH_U;
              for (int i = 0; i < 4; i++) begin
                push_b[2 + i] = raw_hold_nxt[i];
              end
              push_n = RP_CW'(6);
            end
          end
        end else begin
          phase_nxt     = jsu_pkg::PH_TEXT;
          hex_count_nxt = '0;
          cp_req        = 1'b1;
          if (phase_r == jsu_pkg::PH_HEX) begin
            cp_val = 21'(CH_U);
            for (int i = 0; i < 4; i++) begin
              push_b[i] = (3'(i) < {1'b0, hn}) ? raw_hold_r[i] : b;
            end
            push_n = RP_CW'({1'b0, hn} + 3'd1);
          end else begin
            cp_val    = CP_REPL;
            push_b[0] = CH_BSLASH;
            push_b[1] = CH_U;
            for (int i = 0; i < 4; i++) begin
              push_b[2 + i] = (3'(i) < {1'b0, hn}) ? raw_hold_r[i] : b;
            end
            push_n = RP_CW'({1'b0, hn} + 3'd3);
          end
        end
      end
      jsu_pkg::PH_WANT_BS: begin
        if (b == CH_BSLASH) begin
          phase_nxt = jsu_pkg::PH_WANT_U;
        end else begin
          phase_nxt = jsu_pkg::PH_TEXT;
          cp_req    = 1'b1;
          cp_val    = CP_REPL;
          push_b[0] = b;
          push_n    = RP_CW'(1);
        end
      end
      jsu_pkg::PH_WANT_U: begin
        if (b == CH_U) begin
          phase_nxt     = jsu_pkg::PH_LOW_HEX;
          hex_count_nxt = '0;
          hex_accum_nxt = '0;
        end else begin
          phase_nxt = jsu_pkg::PH_TEXT;
          cp_req    = 1'b1;
          cp_val    = CP_REPL;
          push_b[0] = CH_BSLASH;
          push_b[1] = b;
          push_n    = RP_CW'(2);
        end
      end
      default: begin
        phase_nxt = jsu_pkg::PH_TEXT;
        push_b[0] = b;
        push_n    = RP_CW'(1);
      end
    endcase

    // A code point of zero is dropped silently.
    enc = encode_cp(cp_val);
    if (cp_req && (cp_val != '0)) begin
      emit_req = 1'b1;
      unit_n   = enc.n;
      unit_b   = enc.b;
    end

    // Capacity check: the whole unit plus the terminator must fit.
    wsum         = (jsu_pkg::CAP_W + 1)'(wc_r) + (jsu_pkg::CAP_W + 1)'(unit_n) +
                   (jsu_pkg::CAP_W + 1)'(1);
    out_nb       = '0;
    wc_emit      = wc_r;
    stopped_emit = stopped_r;
    if (emit_req && !stopped_r) begin
      if (wsum <= {1'b0, cap_eff}) begin
        out_nb  = unit_n;
        wc_emit = wc_r + jsu_pkg::LEN_W'(unit_n);
      end else begin
        stopped_emit = 1'b1;
      end
    end
    wc_nxt      = wc_emit;
    stopped_nxt = stopped_emit;

    if (fin) begin
      phase_nxt     = jsu_pkg::PH_TEXT;
      hex_accum_nxt = '0;
      hex_count_nxt = '0;
      high_half_nxt = '0;
      raw_need_nxt  = '0;
      raw_have_nxt  = '0;
      wc_nxt        = '0;
      stopped_nxt   = 1'b0;
    end

    step_nxt.nb         = out_nb;
    step_nxt.ub         = unit_b;
    step_nxt.has_status = fin;
    step_nxt.len        = fin ? wc_emit : '0;
    step_nxt.trunc      = fin && stopped_emit;
    // Replays are only loaded into an empty buffer, so the request is done
    // once the buffer drains without a new load.
    step_nxt.item_end   = (rp_cnt_r <= RP_CW'(1)) && (push_n == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= jsu_pkg::PH_TEXT;
      hex_accum_r  <= '0;
      hex_count_r  <= '0;
      high_half_r  <= '0;
      raw_need_r   <= '0;
      raw_have_r   <= '0;
      wc_r         <= '0;
      stopped_r    <= 1'b0;
      rp_cnt_r     <= '0;
      step_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r     <= phase_nxt;
        hex_accum_r <= hex_accum_nxt;
        hex_count_r <= hex_count_nxt;
        high_half_r <= high_half_nxt;
        raw_need_r  <= raw_need_nxt;
        raw_have_r  <= raw_have_nxt;
        wc_r        <= wc_nxt;
        stopped_r   <= stopped_nxt;
        if (push_n != '0) begin
          rp_cnt_r <= push_n;
        end else if (src_rp) begin
          rp_cnt_r <= rp_cnt_r - 1'b1;
        end
      end
      if (can_step) begin
        step_valid_r <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      raw_hold_r <= raw_hold_nxt;
      step_r     <= step_nxt;
      if (push_n != '0) begin
        rp_buf_r <= push_b;
      end else if (src_rp) begin
        rp_buf_r <= {8'h00, rp_buf_r[REPLAY_DEPTH-1:1]};
      end
    end
  end

endmodule

// ----- rtl/jsu_emit.sv -----
// Output side of the JSON string unescaper: serialises decode steps into
// single results and marks the last one of each request. Depends on jsu_pkg.
module jsu_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_valid,
  input  jsu_pkg::step_t     step,
  output logic               step_ready,
  output logic               out_valid,
  output jsu_pkg::out_item_t out_item,
  input  logic               out_ready
);

  logic [2:0]         idx_r, idx_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  jsu_pkg::out_item_t pend_r;
  logic               out_valid_r;
  jsu_pkg::out_item_t out_r, out_nxt;
  logic               load_out, load_pend;
  logic               can_out;
  logic [2:0]         nres;
  logic               is_final;
  jsu_pkg::out_item_t cur;

  assign can_out   = !out_valid_r || out_ready;
  assign nres      = step.nb + {2'b00, step.has_status};
  assign is_final  = (idx_r == nres - 3'd1);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    cur.is_status    = (idx_r >= step.nb);
    cur.out_byte     = cur.is_status ? 8'h00 : step.ub[idx_r[1:0]];
    cur.value_length = cur.is_status ? step.len : '0;
    cur.truncated    = cur.is_status && step.trunc;
    cur.last         = 1'b0;
  end

  always_comb begin
    step_ready     = 1'b0;
    load_out       = 1'b0;
    load_pend      = 1'b0;
    out_nxt        = cur;
    idx_nxt        = idx_r;
    pend_valid_nxt = pend_valid_r;
    if (step_valid) begin
      if (pend_valid_r && ((nres != '0) || step.item_end)) begin
        // The held result turns out not to be last if more results follow.
        if (can_out) begin
          load_out       = 1'b1;
          out_nxt        = pend_r;
          out_nxt.last   = (nres == '0);
          pend_valid_nxt = 1'b0;
          step_ready     = (nres == '0);
        end
      end else if (nres == '0) begin
        step_ready = 1'b1;
      end else if (is_final && !step.item_end) begin
        load_pend      = 1'b1;
        pend_valid_nxt = 1'b1;
        step_ready     = 1'b1;
        idx_nxt        = '0;
      end else if (can_out) begin
        load_out     = 1'b1;
        out_nxt.last = is_final;
        if (is_final) begin
          step_ready = 1'b1;
          idx_nxt    = '0;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      idx_r        <= idx_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= out_nxt;
    end
    if (load_pend) begin
      pend_r <= cur;
    end
  end

endmodule

// ----- rtl/json_string_unescape_utf8.sv -----
// Top level of the streaming JSON string unescaper.
// Depends on jsu_pkg, jsu_front, jsu_engine and jsu_emit.
//
// Feed the bytes of a JSON string body, after its opening quote, one request
// each; an unescaped quote, a zero byte or an end request closes the value
// and a status record (bytes written, truncated flag) follows its bytes.
// Escapes are decoded to UTF-8, surrogate pairs are joined, a broken pair
// gives U+FFFD and the bytes after it are read again as text. Rate: one
// request per clock whenever each request gives at most one result byte
// and the output is not stalled. A request whose unit is several bytes
// sends them one at a time, since results leave through a single output
// register. A replay after a broken surrogate or bad hex digit runs each
// replayed byte (at most six) through the decode engine before the next
// request is taken. When a step's final result may or may not be the
// request's last, it is held back until that is known. A four-entry queue
// lets requests arrive while the output side is stalled. The capacity
// register may only be written while the block is idle; values above the
// built-in limit saturate to it. There is no clearing pass after reset.
module json_string_unescape_utf8 (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  jsu_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output jsu_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic [jsu_pkg::CAP_W-1:0] cfg_wdata
);

  logic [jsu_pkg::CAP_W-1:0] out_capacity_r;
  logic                      q_valid;
  logic [7:0]                q_byte;
  logic                      q_pop;
  logic                      step_valid;
  logic                      step_ready;
  jsu_pkg::step_t            step;

  // Output buffer size in bytes; one byte of it is kept for a terminator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_capacity_r <= jsu_pkg::CAP_RESET;
    end else if (cfg_we) begin
      out_capacity_r <= cfg_wdata;
    end
  end

  // Requests are queued here, with the end request folded into a zero byte.
  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_byte   (q_byte),
    .q_pop    (q_pop)
  );

  // One byte is decoded per step, from the queue or from the replay buffer.
  jsu_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cap        (out_capacity_r),
    .q_valid    (q_valid),
    .q_byte     (q_byte),
    .q_pop      (q_pop),
    .step_valid (step_valid),
    .step       (step),
    .step_ready (step_ready)
  );

  // Each step's unit and status are sent out one result at a time.
  jsu_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (step_valid),
    .step       (step),
    .step_ready (step_ready),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .out_ready  (out_ready)
  );

endmodule

// ----- dv/json_string_unescape_utf8_test.sv -----
// Self-checking bench for json_string_unescape_utf8: random and directed string bodies.
// Holds its own decoder that predicts every result. Depends only on jsu_pkg and the RTL.
`timescale 1ns / 100ps

module json_string_unescape_utf8_test;
  import jsu_pkg::*;

  // Bench timing. The pause lets a replay and the request queue run dry after
  // the last expected result has left the block.
  localparam int DRAIN_CYCLES = 24;
  localparam int TIMEOUT_NS   = 5_000_000;
  localparam int MAX_RESULTS  = 12;
  localparam int REQS_PER_SET = 60;
  localparam int NUM_SETTINGS = 8;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam int unsigned CP_REPLACEMENT = 32'hFFFD;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_item = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_item;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  json_string_unescape_utf8 DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Requests waiting to be driven, and the results that the decoder below
  // says the block owes us, oldest first.
  in_item_t   pending_requests[$];
  out_item_t  expected_results[$];
  out_item_t  step_results[$];
  logic [7:0] frag_bytes[$];

  int n_queued = 0;
  int n_accepted = 0;
  int n_bytes_seen = 0;
  int n_status_seen = 0;
  int n_trunc_seen = 0;
  int n_settings = 1;
  int mismatches = 0;

  int   in_gap_pct = 40;
  int   out_gap_pct = 40;
  int   in_gap = 0;
  int   out_hold = 0;
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;

  // ---------------------------------------------------------------------------
  // Decoder state. It follows the block's own state from reset: the phase of
  // the parser, the \u digits gathered so far, the high half of a surrogate
  // pair, the bytes of a raw UTF-8 sequence (or the hex digits, which share
  // the same store), the bytes written so far for this value and whether the
  // value has hit its capacity.
  // ---------------------------------------------------------------------------
  phase_t           dec_phase = PH_TEXT;
  logic [15:0]      hex_acc = '0;
  logic [2:0]       hex_cnt = '0;
  logic [15:0]      surr_high = '0;
  logic [3:0][7:0]  held = '0;
  logic [2:0]       seq_need = '0;
  logic [2:0]       seq_have = '0;
  logic [LEN_W-1:0] wr_count = '0;
  logic             stop_flag = 1'b0;
  logic [CAP_W-1:0] cap_reg = CAP_RESET;

  function automatic int draw_gap(int pct);
    return ($urandom_range(0, 99) < pct) ? int'($urandom_range(1, 16)) : 0;
  endfunction

  function automatic void add_result(logic st, logic [7:0] ob, logic [LEN_W-1:0] len,
                                     logic tr);
    out_item_t r;
    if (step_results.size() >= MAX_RESULTS) return;
    r.is_status    = st;
    r.out_byte     = ob;
    r.value_length = len;
    r.truncated    = tr;
    r.last         = 1'b0;
    step_results.push_back(r);
  endfunction

  // The usable capacity saturates at the built-in limit, and never above 4096.
  function automatic int usable_capacity();
    int c;
    c = int'(cap_reg);
    if (c > MAX_CAPACITY) c = MAX_CAPACITY;
    if (c > 4096) c = 4096;
    return c;
  endfunction

  // A unit is written whole or not at all; one byte is kept for the terminator.
  function automatic void put_unit(logic [3:0][7:0] u, int n);
    if (stop_flag) return;
    if (int'(wr_count) + n + 1 > usable_capacity()) begin
      stop_flag = 1'b1;
      return;
    end
    for (int i = 0; i < n && i < 4; i++) add_result(1'b0, u[i], '0, 1'b0);
    wr_count = wr_count + LEN_W'(n);
  endfunction

  function automatic void put_code(int unsigned cp);
    logic [3:0][7:0] e;
    int n;
    e = '0;
    if (cp == 0) return;
    if (cp < 32'h80) begin
      e[0] = cp[7:0];
      n = 1;
    end else if (cp < 32'h800) begin
      e[0] = 8'(32'hC0 | (cp >> 6));
      e[1] = 8'(32'h80 | (cp & 32'h3F));
      n = 2;
    end else if (cp < 32'h10000) begin
      e[0] = 8'(32'hE0 | (cp >> 12));
      e[1] = 8'(32'h80 | ((cp >> 6) & 32'h3F));
      e[2] = 8'(32'h80 | (cp & 32'h3F));
      n = 3;
    end else begin
      e[0] = 8'(32'hF0 | ((cp >> 18) & 32'h07));
      e[1] = 8'(32'h80 | ((cp >> 12) & 32'h3F));
      e[2] = 8'(32'h80 | ((cp >> 6) & 32'h3F));
      e[3] = 8'(32'h80 | (cp & 32'h3F));
      n = 4;
    end
    put_unit(e, n);
  endfunction

  // Length of a raw UTF-8 unit from its lead byte; a bad lead stands alone.
  function automatic int utf8_len(logic [7:0] b);
    if (b < 8'h80) return 1;
    if ((b & 8'hE0) == 8'hC0) return 2;
    if ((b & 8'hF0) == 8'hE0) return 3;
    if ((b & 8'hF8) == 8'hF0) return 4;
    return 1;
  endfunction

  function automatic int hex_value(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic void close_value();
    add_result(1'b1, 8'h00, wr_count, stop_flag);
    dec_phase = PH_TEXT;
    hex_acc   = '0;
    hex_cnt   = '0;
    surr_high = '0;
    seq_need  = '0;
    seq_have  = '0;
    wr_count  = '0;
    stop_flag = 1'b0;
  endfunction

  // One body byte through the parser. Broken surrogates and bad hex digits
  // push the held text back through here, hence the recursion.
  function automatic void decode_byte(logic [7:0] b);
    logic [3:0][7:0] saved;
    logic [15:0]     k;
    int              d;
    int              n;
    case (dec_phase)
      PH_TEXT: begin
        if (b == 8'h00 || b == CH_QUOTE) close_value();
        else if (b == CH_BSLASH) dec_phase = PH_ESC;
        else if (utf8_len(b) == 1) put_unit({24'h0, b}, 1);
        else begin
          held[0]   = b;
          seq_need  = 3'(utf8_len(b));
          seq_have  = 3'd1;
          dec_phase = PH_RAW;
        end
      end
      PH_RAW: begin
        if (b == 8'h00 || b == CH_QUOTE) begin
          put_unit(held, int'(seq_have));
          close_value();
        end else begin
          held[seq_have[1:0]] = b;
          seq_have = seq_have + 3'd1;
          if (seq_have >= seq_need) begin
            put_unit(held, int'(seq_need));
            dec_phase = PH_TEXT;
            seq_have  = '0;
            seq_need  = '0;
          end
        end
      end
      PH_ESC: begin
        dec_phase = PH_TEXT;
        case (b)
          8'h00:                        close_value();
          "n":                          put_code(32'h0A);
          "t":                          put_code(32'h09);
          "r":                          put_code(32'h0D);
          "b":                          put_code(32'h08);
          "f":                          put_code(32'h0C);
          CH_QUOTE, CH_BSLASH, CH_SLASH: put_code(32'(b));
          CH_U: begin
            dec_phase = PH_HEX;
            hex_cnt   = '0;
            hex_acc   = '0;
          end
          default:                      put_unit({24'h0, b}, 1);
        endcase
      end
      PH_HEX, PH_LOW_HEX: begin
        d = hex_value(b);
        if (d >= 0) begin
          held[hex_cnt[1:0]] = b;
          hex_acc = {hex_acc[11:0], 4'(d)};
          hex_cnt = hex_cnt + 3'd1;
          if (hex_cnt >= 3'd4) begin
            k = hex_acc;
            if (dec_phase == PH_HEX) begin
              dec_phase = PH_TEXT;
              hex_cnt   = '0;
              if (k >= 16'hD800 && k <= 16'hDBFF) begin
                surr_high = k;
                dec_phase = PH_WANT_BS;
              end else if (k >= 16'hDC00 && k <= 16'hDFFF) put_code(CP_REPLACEMENT);
              else put_code(32'(k));
            end else begin
              dec_phase = PH_TEXT;
              hex_cnt   = '0;
              if (k >= 16'hDC00 && k <= 16'hDFFF) begin
                put_code(32'h10000 + ((32'(surr_high) - 32'hD800) << 10)
                         + (32'(k) - 32'hDC00));
              end else begin
                saved = held;
                put_code(CP_REPLACEMENT);
                decode_byte(CH_BSLASH);
                decode_byte(CH_U);
                for (int i = 0; i < 4; i++) decode_byte(saved[i]);
              end
            end
          end
        end else begin
          n     = int'(hex_cnt[1:0]);
          saved = held;
          if (dec_phase == PH_HEX) begin
            dec_phase = PH_TEXT;
            hex_cnt   = '0;
            put_code(32'(CH_U));
          end else begin
            dec_phase = PH_TEXT;
            hex_cnt   = '0;
            put_code(CP_REPLACEMENT);
            decode_byte(CH_BSLASH);
            decode_byte(CH_U);
          end
          for (int i = 0; i < n; i++) decode_byte(saved[i]);
          decode_byte(b);
        end
      end
      PH_WANT_BS: begin
        if (b == CH_BSLASH) dec_phase = PH_WANT_U;
        else begin
          dec_phase = PH_TEXT;
          put_code(CP_REPLACEMENT);
          decode_byte(b);
        end
      end
      PH_WANT_U: begin
        if (b == CH_U) begin
          dec_phase = PH_LOW_HEX;
          hex_cnt   = '0;
          hex_acc   = '0;
        end else begin
          dec_phase = PH_TEXT;
          put_code(CP_REPLACEMENT);
          decode_byte(CH_BSLASH);
          decode_byte(b);
        end
      end
      default: begin
        dec_phase = PH_TEXT;
        decode_byte(b);
      end
    endcase
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Requests go onto the pending queue; the driver takes
  // them from there one at a time.
  // ---------------------------------------------------------------------------
  task automatic queue_byte(logic [7:0] b);
    pending_requests.push_back(in_item_t'{1'b0, b});
    n_queued++;
  endtask

  // An end request; its byte field is ignored, so it carries noise.
  task automatic queue_end();
    pending_requests.push_back(in_item_t'{1'b1, 8'($urandom_range(0, 255))});
    n_queued++;
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 4'd10) return 8'("0") + 8'(nib);
    return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(nib) - 8'd10;
  endfunction

  // Appends \u and four hex digits of mixed case.
  task automatic frag_escape_u(logic [15:0] v);
    frag_bytes.push_back(CH_BSLASH);
    frag_bytes.push_back(CH_U);
    for (int i = 3; i >= 0; i--) frag_bytes.push_back(hex_char(v[4*i +: 4]));
  endtask

  // A whole value: mostly well-formed pieces of text with random content,
  // now and then noise or a piece cut short, then a closing quote, a zero
  // byte or an end request.
  task automatic queue_value();
    string      esc_set = "ntrbf\"\\/";
    int         ntok;
    int         keep;
    int         len;
    bit         cut;
    logic [7:0] b;
    logic [15:0] cp;
    ntok = $urandom_range(0, 10);
    cut  = 1'b0;
    for (int t = 0; t < ntok && !cut; t++) begin
      frag_bytes.delete();
      case ($urandom_range(0, 13))
        0, 1, 2: begin
          b = 8'($urandom_range(8'h20, 8'h7E));
          if (b == CH_QUOTE || b == CH_BSLASH) b = "x";
          frag_bytes.push_back(b);
        end
        3: begin
          frag_bytes.push_back(CH_BSLASH);
          frag_bytes.push_back(esc_set[$urandom_range(0, 7)]);
        end
        4: begin
          frag_bytes.push_back(CH_BSLASH);
          frag_bytes.push_back(8'($urandom_range(0, 255)));
        end
        5: begin
          case ($urandom_range(0, 4))
            0:       cp = 16'h0000;
            1:       cp = 16'($urandom_range(1, 16'h7F));
            2:       cp = 16'($urandom_range(16'h80, 16'h7FF));
            3:       cp = 16'($urandom_range(16'h800, 16'hFFFF));
            default: cp = 16'($urandom_range(16'hDC00, 16'hDFFF));
          endcase
          frag_escape_u(cp);
        end
        6: begin
          frag_escape_u(16'($urandom_range(16'hD800, 16'hDBFF)));
          frag_escape_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end
        7: begin
          // A high surrogate followed by anything but a proper low half.
          frag_escape_u(16'($urandom_range(16'hD800, 16'hDBFF)));
          case ($urandom_range(0, 4))
            0: frag_bytes.push_back(8'($urandom_range("g", "z")));
            1: begin
              frag_bytes.push_back(CH_BSLASH);
              frag_bytes.push_back("n");
            end
            2: frag_escape_u(16'($urandom_range(0, 16'hDBFF)));
            3: begin
              frag_bytes.push_back(CH_BSLASH);
              frag_bytes.push_back(CH_U);
              len = $urandom_range(0, 3);
              repeat (len) frag_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
              frag_bytes.push_back(8'($urandom_range("g", "z")));
            end
            default: ;
          endcase
        end
        8: begin
          frag_bytes.push_back(CH_BSLASH);
          frag_bytes.push_back(CH_U);
          len = $urandom_range(0, 3);
          repeat (len) frag_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
          do b = 8'($urandom_range(0, 255)); while (hex_value(b) >= 0);
          frag_bytes.push_back(b);
        end
        9, 10: begin
          len = $urandom_range(2, 4);
          case (len)
            2:       frag_bytes.push_back(8'($urandom_range(8'hC0, 8'hDF)));
            3:       frag_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            default: frag_bytes.push_back(8'($urandom_range(8'hF0, 8'hF7)));
          endcase
          repeat (len - 1) frag_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        11: begin
          if ($urandom_range(0, 1)) frag_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
          else frag_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
        end
        default: frag_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
      if (frag_bytes.size() > 1 && $urandom_range(0, 19) == 0) begin
        keep = $urandom_range(1, frag_bytes.size() - 1);
        while (frag_bytes.size() > keep) void'(frag_bytes.pop_back());
        cut = 1'b1;
      end
      foreach (frag_bytes[i]) queue_byte(frag_bytes[i]);
    end
    case ($urandom_range(0, 9))
      7:       queue_byte(8'h00);
      8, 9:    queue_end();
      default: queue_byte(CH_QUOTE);
    endcase
  endtask

  // Holds the sender back until the block has handed over every result it
  // owes, then gives it time to finish any replay that yields nothing.
  task automatic wait_drained();
    while (n_accepted != n_queued || expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sender. A request is held, unchanged, until it is accepted. After each
  // acceptance the sender idles for the number of cycles it drew when it
  // loaded that request.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item  <= '0;
      in_gap   <= 0;
    end else if (!in_valid || in_fire) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pending_requests.size() != 0) begin
        in_item  <= pending_requests.pop_front();
        in_valid <= 1'b1;
        in_gap   <= draw_gap(in_gap_pct);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. After each result it stalls for a freshly drawn number of cycles.
  always @(negedge clk) begin : receiver
    int stall;
    stall = draw_gap(out_gap_pct);
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold  <= 0;
    end else if (out_fire) begin
      out_hold  <= stall;
      out_ready <= (stall == 0);
    end else if (out_hold > 0) begin
      out_hold  <= out_hold - 1;
      out_ready <= (out_hold == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Results are checked against the oldest expectation before the
  // request accepted on the same edge adds its own, so order is kept.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    out_item_t want;
    in_fire  <= rst_n && in_valid && in_ready;
    out_fire <= rst_n && out_valid && out_ready;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result 0x%0h arrived with nothing expected", out_item);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("is_status", want.is_status, out_item.is_status);
        check_field("out_byte", want.out_byte, out_item.out_byte);
        check_field("value_length", want.value_length, out_item.value_length);
        check_field("truncated", want.truncated, out_item.truncated);
        check_field("last", want.last, out_item.last);
      end
      if (out_item.is_status) begin
        n_status_seen++;
        if (out_item.truncated) n_trunc_seen++;
      end else begin
        n_bytes_seen++;
      end
    end
    if (rst_n && in_valid && in_ready) begin
      step_results.delete();
      decode_byte(in_item.cmd ? 8'h00 : in_item.in_byte);
      foreach (step_results[i]) begin
        want      = step_results[i];
        want.last = (i == step_results.size() - 1);
        expected_results.push_back(want);
      end
      n_accepted++;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence. A short directed set runs first at the reset capacity,
  // then each capacity setting gets its own batch of random values, from
  // zero (every unit is refused) through tiny buffers that truncate often,
  // up to the largest value the register holds, which saturates.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int caps[NUM_SETTINGS];
    int base;
    caps = '{0, 1, 2, 9, 8191, 4096, 24, 0};
    caps[NUM_SETTINGS-1] = $urandom_range(1, 40);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Top lead byte on its own, an escaped quote, then a three-byte sequence
    // cut off by the closing quote.
    queue_byte(8'hFF);
    queue_text("\\\"");
    queue_byte(8'hE2);
    queue_byte(8'h82);
    queue_byte(CH_QUOTE);
    // An unknown escape, a \u broken by a non-hex digit, a newline escape,
    // and a zero byte standing in for the closing quote.
    queue_text("\\q\\u0G\\n");
    queue_byte(8'h00);
    // \u0000 writes nothing; a backslash right before the end request is lost.
    queue_text("\\u0000\\");
    queue_end();

    for (int p = 0; p <= NUM_SETTINGS; p++) begin
      if (p > 0) begin
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CAP_W'(caps[p-1]);
        cap_reg    = CAP_W'(caps[p-1]);
        @(negedge clk);
        cfg_we <= 1'b0;
        n_settings++;
      end
      // Rotate through no idling at all, light idling and heavy idling.
      case (p % 3)
        0: begin
          in_gap_pct  = 0;
          out_gap_pct = 0;
        end
        1: begin
          in_gap_pct  = 30;
          out_gap_pct = 30;
        end
        default: begin
          in_gap_pct  = 70;
          out_gap_pct = 50;
        end
      endcase
      base = n_queued;
      while (n_queued - base < REQS_PER_SET) queue_value();
    end

    wait_drained();
    $display("Checked %0d decoded bytes and %0d end-of-value records from %0d requests,",
             n_bytes_seen, n_status_seen, n_accepted);
    $display("over %0d capacity settings; %0d values were cut short by capacity.",
             n_settings, n_trunc_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[json_string_unescape_utf8] OK");
    end else begin
      $display("[json_string_unescape_utf8] ERROR");
    end
    $finish;
  end

  // Safety net in case the block stops answering.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("[json_string_unescape_utf8] ERROR");
    $finish;
  end

endmodule
